>>> rtl/core/cpcr_pkg.sv
// Shared types, constants and helpers for the circle pair collision core.
// No dependencies; imported by every other file of the block.
package cpcr_pkg;

    // 0.001 in Q32.32, the lower clamp of the squared distance
    localparam logic [63:0] MIN_DIST_SQ  = 64'd4294967;
    // 1.0 in Q16.16
    localparam logic [17:0] ONE_Q16      = 18'd65536;
    localparam logic [16:0] BOUNCE_RESET = 17'd32768;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    // One classified pair as it waits between the front and the back
    typedef struct packed {
        logic signed [32:0] ox;
        logic signed [32:0] oy;
        logic        [31:0] rs;
        logic        [63:0] d2;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               hit;
    } cpcr_item_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } cpcr_qstat_t;

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -41'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/cpcr_front.sv
// Front of the collision core: takes pairs, forms the offset, squared distance
// and overlap flag over four stages. Depends on cpcr_pkg.
module cpcr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           first_pos_x,
    input  logic signed [31:0]           first_pos_y,
    input  logic signed [31:0]           first_dx,
    input  logic signed [31:0]           first_dy,
    input  logic        [30:0]           first_radius,
    input  logic signed [31:0]           second_pos_x,
    input  logic signed [31:0]           second_pos_y,
    input  logic signed [31:0]           second_dx,
    input  logic signed [31:0]           second_dy,
    input  logic        [30:0]           second_radius,
    input  cpcr_pkg::cpcr_qstat_t        qstat,
    output logic                         push,
    output cpcr_pkg::cpcr_item_t         item
);
    import cpcr_pkg::*;

    logic en;

    // stage 1: raw fields
    logic               s1_v_reg;
    logic signed [31:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic signed [31:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic        [30:0] r0_reg, r1_reg;

    // stage 2: offset and radius sum
    logic               s2_v_reg;
    logic signed [32:0] ox2_reg, oy2_reg;
    logic        [31:0] ux2_reg, uy2_reg, rs2_reg;
    logic signed [31:0] ax2_reg, ay2_reg, bx2_reg, by2_reg;

    // stage 3: squares
    logic               s3_v_reg;
    logic signed [32:0] ox3_reg, oy3_reg;
    logic        [31:0] rs3_reg;
    logic        [63:0] sqx3_reg, sqy3_reg, rr3_reg;
    logic signed [31:0] ax3_reg, ay3_reg, bx3_reg, by3_reg;

    // stage 4: clamp and compare
    logic               s4_v_reg;
    cpcr_item_t         item4_reg;

    logic signed [32:0] ox_next, oy_next;
    logic        [64:0] d2_sum, d2_clamp;

    assign en       = !s4_v_reg || !qstat.full;
    assign in_ready = en;
    assign push     = s4_v_reg && !qstat.full;
    assign item     = item4_reg;

    assign ox_next  = 33'(p1x_reg) - 33'(p0x_reg);
    assign oy_next  = 33'(p1y_reg) - 33'(p0y_reg);
    assign d2_sum   = 65'(sqx3_reg) + 65'(sqy3_reg);
    assign d2_clamp = (d2_sum < 65'(MIN_DIST_SQ)) ? 65'(MIN_DIST_SQ) : d2_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0x_reg <= first_pos_x;
            p0y_reg <= first_pos_y;
            p1x_reg <= second_pos_x;
            p1y_reg <= second_pos_y;
            ax1_reg <= first_dx;
            ay1_reg <= first_dy;
            bx1_reg <= second_dx;
            by1_reg <= second_dy;
            r0_reg  <= first_radius;
            r1_reg  <= second_radius;

            ox2_reg <= ox_next;
            oy2_reg <= oy_next;
            // offsets stay within +-(2^32 - 1), so the magnitude fits 32 bits
            ux2_reg <= ox_next[32] ? 32'(-ox_next) : ox_next[31:0];
            uy2_reg <= oy_next[32] ? 32'(-oy_next) : oy_next[31:0];
            rs2_reg <= 32'(r0_reg) + 32'(r1_reg);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;

            ox3_reg  <= ox2_reg;
            oy3_reg  <= oy2_reg;
            rs3_reg  <= rs2_reg;
            sqx3_reg <= 64'(ux2_reg) * 64'(ux2_reg);
            sqy3_reg <= 64'(uy2_reg) * 64'(uy2_reg);
            rr3_reg  <= 64'(rs2_reg) * 64'(rs2_reg);
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;

            item4_reg.ox  <= ox3_reg;
            item4_reg.oy  <= oy3_reg;
            item4_reg.rs  <= rs3_reg;
            // a sum past 64 bits never overlaps; the low word keeps sqrt sane
            item4_reg.d2  <= d2_clamp[63:0] < MIN_DIST_SQ ? MIN_DIST_SQ : d2_clamp[63:0];
            item4_reg.ax  <= ax3_reg;
            item4_reg.ay  <= ay3_reg;
            item4_reg.bx  <= bx3_reg;
            item4_reg.by  <= by3_reg;
            item4_reg.hit <= d2_clamp < 65'(rr3_reg);
        end
    end

endmodule

>>> rtl/core/cpcr_queue.sv
// Short flip-flop queue between the front and back of the collision core.
// Depends on cpcr_pkg for the item type.
module cpcr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cpcr_pkg::cpcr_item_t  wr_item,
    input  logic                  pop,
    output cpcr_pkg::cpcr_item_t  rd_item,
    output cpcr_pkg::cpcr_qstat_t qstat
);
    import cpcr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cpcr_item_t    mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_item     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> rtl/core/cpcr_back.sv
// Back of the collision core: square root, normal division, push and
// restitution exchange, ending in the output register. Depends on cpcr_pkg.
module cpcr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [16:0]           bounce,
    input  cpcr_pkg::cpcr_qstat_t qstat,
    input  cpcr_pkg::cpcr_item_t  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    new_first_dx,
    output logic signed [31:0]    new_first_dy,
    output logic signed [31:0]    new_second_dx,
    output logic signed [31:0]    new_second_dy,
    output logic                  overlapped
);
    import cpcr_pkg::*;

    logic en;

    // ---------------- square root, one result bit per stage
    logic        sq_v_reg    [0:SQRT_STEPS];
    logic [63:0] sq_rem_reg  [0:SQRT_STEPS];
    logic [31:0] sq_res_reg  [0:SQRT_STEPS];
    cpcr_item_t  sq_item_reg [0:SQRT_STEPS];

    // ---------------- division, one quotient bit per stage
    logic        dv_v_reg    [0:DIV_STEPS];
    logic [48:0] dv_remx_reg [0:DIV_STEPS];
    logic [48:0] dv_remy_reg [0:DIV_STEPS];
    logic [16:0] dv_qx_reg   [0:DIV_STEPS];
    logic [16:0] dv_qy_reg   [0:DIV_STEPS];
    logic [31:0] dv_len_reg  [0:DIV_STEPS];
    cpcr_item_t  dv_item_reg [0:DIV_STEPS];

    // ---------------- arithmetic tail
    logic               m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg;
    logic               m5_v_reg, m6_v_reg, m7_v_reg, m8_v_reg;
    logic               m1_hit_reg, m2_hit_reg, m3_hit_reg, m4_hit_reg;
    logic               m5_hit_reg, m6_hit_reg, m7_hit_reg, m8_hit_reg;
    logic signed [17:0] m1_nx_reg, m1_ny_reg, m2_nx_reg, m2_ny_reg, m3_nx_reg, m3_ny_reg;
    logic signed [17:0] m4_nx_reg, m4_ny_reg, m5_nx_reg, m5_ny_reg, m6_nx_reg, m6_ny_reg;
    logic signed [32:0] m1_p_reg;
    logic signed [31:0] m1_ax_reg, m1_ay_reg, m1_bx_reg, m1_by_reg;
    logic signed [31:0] m2_ax_reg, m2_ay_reg, m2_bx_reg, m2_by_reg;
    logic signed [50:0] m2_prx_reg, m2_pry_reg;
    logic signed [31:0] m3_ax_reg, m3_ay_reg, m3_bx_reg, m3_by_reg;
    logic signed [31:0] m4_ax_reg, m4_ay_reg, m4_bx_reg, m4_by_reg;
    logic signed [50:0] m4_pvx_reg, m4_pvy_reg;
    logic signed [31:0] m5_ax_reg, m5_ay_reg, m5_bx_reg, m5_by_reg;
    logic signed [35:0] m5_rel_reg;
    logic signed [31:0] m6_ax_reg, m6_ay_reg, m6_bx_reg, m6_by_reg;
    logic signed [54:0] m6_pex_reg;
    logic signed [31:0] m7_ax_reg, m7_ay_reg, m7_bx_reg, m7_by_reg;
    logic signed [56:0] m7_pqx_reg, m7_pqy_reg;
    logic               m7_epos_reg;
    logic signed [31:0] m8_ax_reg, m8_ay_reg, m8_bx_reg, m8_by_reg;

    cpcr_item_t         dv_last;
    logic        [31:0] sq_len;
    cpcr_item_t         sq_last;
    logic        [31:0] mag_x, mag_y;
    logic signed [17:0] nx_next, ny_next;
    logic signed [33:0] px, py;
    logic signed [32:0] vx, vy;
    logic signed [51:0] vsum;
    logic signed [18:0] kfac;
    logic signed [38:0] ex;
    logic signed [39:0] qx, qy;
    logic               apply_q;

    assign en    = !m8_v_reg || out_ready;
    assign q_pop = en && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_item_reg[0] <= q_item;
            sq_rem_reg[0]  <= q_item.d2;
            sq_res_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int BIT = SQRT_STEPS - 1 - k;
        logic [64:0] trial;
        logic        take;

        // (res + 2^BIT)^2 - res^2, res having no bits at or below BIT
        assign trial = (65'(sq_res_reg[k]) << (BIT + 1)) | (65'd1 << (2 * BIT));
        assign take  = 65'(sq_rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_rem_reg[k+1]  <= take ? 64'(65'(sq_rem_reg[k]) - trial) : sq_rem_reg[k];
                sq_res_reg[k+1]  <= take ? (sq_res_reg[k] | (32'd1 << BIT)) : sq_res_reg[k];
            end
        end
    end

    assign sq_len  = sq_res_reg[SQRT_STEPS];
    assign sq_last = sq_item_reg[SQRT_STEPS];
    assign mag_x   = sq_last.ox[32] ? 32'(-sq_last.ox) : sq_last.ox[31:0];
    assign mag_y   = sq_last.oy[32] ? 32'(-sq_last.oy) : sq_last.oy[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_item_reg[0] <= sq_last;
            dv_len_reg[0]  <= sq_len;
            dv_remx_reg[0] <= {1'b0, mag_x, 16'd0};
            dv_remy_reg[0] <= {1'b0, mag_y, 16'd0};
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    // |offset| <= len on overlap, so the quotient never exceeds 1.0
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int BIT = DIV_STEPS - 1 - j;
        logic [48:0] dsub;
        logic        tx, ty;

        assign dsub = 49'(dv_len_reg[j]) << BIT;
        assign tx   = dv_remx_reg[j] >= dsub;
        assign ty   = dv_remy_reg[j] >= dsub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_item_reg[j+1] <= dv_item_reg[j];
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_remx_reg[j+1] <= tx ? dv_remx_reg[j] - dsub : dv_remx_reg[j];
                dv_remy_reg[j+1] <= ty ? dv_remy_reg[j] - dsub : dv_remy_reg[j];
                dv_qx_reg[j+1]   <= tx ? (dv_qx_reg[j] | (17'd1 << BIT)) : dv_qx_reg[j];
                dv_qy_reg[j+1]   <= ty ? (dv_qy_reg[j] | (17'd1 << BIT)) : dv_qy_reg[j];
            end
        end
    end

    assign dv_last = dv_item_reg[DIV_STEPS];
    assign nx_next = dv_last.ox[32] ? -$signed({1'b0, dv_qx_reg[DIV_STEPS]})
                                    :  $signed({1'b0, dv_qx_reg[DIV_STEPS]});
    assign ny_next = dv_last.oy[32] ? -$signed({1'b0, dv_qy_reg[DIV_STEPS]})
                                    :  $signed({1'b0, dv_qy_reg[DIV_STEPS]});

    assign px      = m2_prx_reg[50:17];
    assign py      = m2_pry_reg[50:17];
    assign vx      = 33'(m3_ax_reg) - 33'(m3_bx_reg);
    assign vy      = 33'(m3_ay_reg) - 33'(m3_by_reg);
    assign vsum    = 52'(m4_pvx_reg) + 52'(m4_pvy_reg);
    assign kfac    = $signed({1'b0, ONE_Q16 + 18'(bounce)});
    assign ex      = m6_pex_reg[54:16];
    assign qx      = m7_pqx_reg[56:17];
    assign qy      = m7_pqy_reg[56:17];
    assign apply_q = m7_hit_reg && m7_epos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
            m5_v_reg <= 1'b0;
            m6_v_reg <= 1'b0;
            m7_v_reg <= 1'b0;
            m8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= dv_v_reg[DIV_STEPS];
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
            m5_v_reg <= m4_v_reg;
            m6_v_reg <= m5_v_reg;
            m7_v_reg <= m6_v_reg;
            m8_v_reg <= m7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // normal and depth
            m1_hit_reg <= dv_last.hit;
            m1_nx_reg  <= nx_next;
            m1_ny_reg  <= ny_next;
            m1_p_reg   <= $signed({1'b0, dv_last.rs}) - $signed({1'b0, dv_len_reg[DIV_STEPS]});
            m1_ax_reg  <= dv_last.ax;
            m1_ay_reg  <= dv_last.ay;
            m1_bx_reg  <= dv_last.bx;
            m1_by_reg  <= dv_last.by;

            // push products
            m2_hit_reg <= m1_hit_reg;
            m2_nx_reg  <= m1_nx_reg;
            m2_ny_reg  <= m1_ny_reg;
            m2_prx_reg <= m1_nx_reg * m1_p_reg;
            m2_pry_reg <= m1_ny_reg * m1_p_reg;
            m2_ax_reg  <= m1_ax_reg;
            m2_ay_reg  <= m1_ay_reg;
            m2_bx_reg  <= m1_bx_reg;
            m2_by_reg  <= m1_by_reg;

            // apply push
            m3_hit_reg <= m2_hit_reg;
            m3_nx_reg  <= m2_nx_reg;
            m3_ny_reg  <= m2_ny_reg;
            m3_ax_reg  <= m2_hit_reg ? sat32(41'(m2_ax_reg) - 41'(px)) : m2_ax_reg;
            m3_ay_reg  <= m2_hit_reg ? sat32(41'(m2_ay_reg) - 41'(py)) : m2_ay_reg;
            m3_bx_reg  <= m2_hit_reg ? sat32(41'(m2_bx_reg) + 41'(px)) : m2_bx_reg;
            m3_by_reg  <= m2_hit_reg ? sat32(41'(m2_by_reg) + 41'(py)) : m2_by_reg;

            // relative speed products
            m4_hit_reg <= m3_hit_reg;
            m4_nx_reg  <= m3_nx_reg;
            m4_ny_reg  <= m3_ny_reg;
            m4_pvx_reg <= vx * m3_nx_reg;
            m4_pvy_reg <= vy * m3_ny_reg;
            m4_ax_reg  <= m3_ax_reg;
            m4_ay_reg  <= m3_ay_reg;
            m4_bx_reg  <= m3_bx_reg;
            m4_by_reg  <= m3_by_reg;

            m5_hit_reg <= m4_hit_reg;
            m5_nx_reg  <= m4_nx_reg;
            m5_ny_reg  <= m4_ny_reg;
            m5_rel_reg <= vsum[51:16];
            m5_ax_reg  <= m4_ax_reg;
            m5_ay_reg  <= m4_ay_reg;
            m5_bx_reg  <= m4_bx_reg;
            m5_by_reg  <= m4_by_reg;

            // scale by (1 + bounce)
            m6_hit_reg <= m5_hit_reg;
            m6_nx_reg  <= m5_nx_reg;
            m6_ny_reg  <= m5_ny_reg;
            m6_pex_reg <= kfac * m5_rel_reg;
            m6_ax_reg  <= m5_ax_reg;
            m6_ay_reg  <= m5_ay_reg;
            m6_bx_reg  <= m5_bx_reg;
            m6_by_reg  <= m5_by_reg;

            // exchange products
            m7_hit_reg  <= m6_hit_reg;
            m7_pqx_reg  <= m6_nx_reg * ex;
            m7_pqy_reg  <= m6_ny_reg * ex;
            m7_epos_reg <= !ex[38] && (ex != '0);
            m7_ax_reg   <= m6_ax_reg;
            m7_ay_reg   <= m6_ay_reg;
            m7_bx_reg   <= m6_bx_reg;
            m7_by_reg   <= m6_by_reg;

            // output register
            m8_hit_reg <= m7_hit_reg;
            m8_ax_reg  <= apply_q ? sat32(41'(m7_ax_reg) - 41'(qx)) : m7_ax_reg;
            m8_ay_reg  <= apply_q ? sat32(41'(m7_ay_reg) - 41'(qy)) : m7_ay_reg;
            m8_bx_reg  <= apply_q ? sat32(41'(m7_bx_reg) + 41'(qx)) : m7_bx_reg;
            m8_by_reg  <= apply_q ? sat32(41'(m7_by_reg) + 41'(qy)) : m7_by_reg;
        end
    end

    assign out_valid     = m8_v_reg;
    assign new_first_dx  = m8_ax_reg;
    assign new_first_dy  = m8_ay_reg;
    assign new_second_dx = m8_bx_reg;
    assign new_second_dy = m8_by_reg;
    assign overlapped    = m8_hit_reg;

endmodule

>>> rtl/core/circle_pair_collision_resolve_core.sv
// Circle pair collision core: pushes two overlapping circles apart and
// exchanges restitution along the contact normal, Q16.16 throughout.
//
// Input stream s_*: one particle pair per transaction (fields in s_tdata).
// Output stream m_*: one result per pair, in order; overlap flag in m_tuser.
// cfg_wr_en/cfg_wr_data write the bounce factor; write only while idle.
//
// Throughput: one pair per cycle while m_tready is high. m_tvalid rises once the
// pair has passed 4 front stages, the queue slot, the 32-stage square root and
// 17-stage divider each behind an input register, and the 8-stage arithmetic
// tail, with the first front stage loading at the accepting edge.
// If m_tready drops, the back pipeline holds and the queue between front and
// back fills (depth QUEUE_DEPTH); once it is full and the last front stage
// holds a pair, s_tready falls.
// Reset clears all valid state and sets bounce to 0.5; nothing else needs
// clearing, no pair depends on another.
// Depends on cpcr_pkg, cpcr_front, cpcr_queue and cpcr_back.
module circle_pair_collision_resolve_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_pos_x, first_pos_y, first_dx, first_dy, first_radius(31),
    // second_pos_x, second_pos_y, second_dx, second_dy, second_radius(31), 2 pad
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_first_dx, new_first_dy, new_second_dx, new_second_dy
    output logic [127:0] m_tdata,
    // overlapped
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data
);
    import cpcr_pkg::*;

    logic [16:0]        bounce_reg;
    cpcr_qstat_t        qstat;
    cpcr_item_t         push_item, pop_item;
    logic               push, pop;
    logic signed [31:0] nfdx, nfdy, nsdx, nsdy;
    logic               ovl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= BOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            bounce_reg <= cfg_wr_data;
        end
    end

    cpcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .first_pos_x   (s_tdata[31:0]),
        .first_pos_y   (s_tdata[63:32]),
        .first_dx      (s_tdata[95:64]),
        .first_dy      (s_tdata[127:96]),
        .first_radius  (s_tdata[158:128]),
        .second_pos_x  (s_tdata[190:159]),
        .second_pos_y  (s_tdata[222:191]),
        .second_dx     (s_tdata[254:223]),
        .second_dy     (s_tdata[286:255]),
        .second_radius (s_tdata[317:287]),
        .qstat         (qstat),
        .push          (push),
        .item          (push_item)
    );

    cpcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (pop_item),
        .qstat   (qstat)
    );

    cpcr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .bounce        (bounce_reg),
        .qstat         (qstat),
        .q_item        (pop_item),
        .q_pop         (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .new_first_dx  (nfdx),
        .new_first_dy  (nfdy),
        .new_second_dx (nsdx),
        .new_second_dy (nsdy),
        .overlapped    (ovl)
    );

    assign m_tdata = {nsdy, nsdx, nfdy, nfdx};
    assign m_tuser = ovl;

endmodule

>>> tb/testbench.sv
// Testbench for circle_pair_collision_resolve_core: streams particle pairs,
// predicts each result in Q16.16 and compares it with the output stream.
// Depends on cpcr_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import cpcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] ndy2;
        logic signed [31:0] ndx2;
        logic signed [31:0] ndy1;
        logic signed [31:0] ndx1;
        logic               hit;
    } contact_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en;
    logic [16:0]  cfg_wr_data;

    logic [16:0]  bounce_q;
    contact_t     contact_q[$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off;
    int           quiet_cycles;

    circle_pair_collision_resolve_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint fl_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_v;
        res = 0;
        bit_v = 64'h1 << 62;
        while (bit_v > x)
        begin
            bit_v = bit_v >> 2;
        end
        while (bit_v != 0)
        begin
            if (x >= res + bit_v)
            begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic contact_t resolve_pair(input logic [319:0] d, input logic [16:0] bnc);
        contact_t   c;
        longint     p0x, p0y, ax, ay, p1x, p1y, bx, by, ox, oy;
        longint     len, depth, nx, ny, px, py, rel, ex, qx, qy;
        logic [64:0] d2;
        logic [63:0] rs, d2c;
        p0x = longint'($signed(d[31:0]));
        p0y = longint'($signed(d[63:32]));
        ax  = longint'($signed(d[95:64]));
        ay  = longint'($signed(d[127:96]));
        p1x = longint'($signed(d[190:159]));
        p1y = longint'($signed(d[222:191]));
        bx  = longint'($signed(d[254:223]));
        by  = longint'($signed(d[286:255]));
        rs  = 64'(d[158:128]) + 64'(d[317:287]);
        ox = p1x - p0x;
        oy = p1y - p0y;
        // squares of 33-bit offsets are taken as unsigned 64-bit values
        d2 = {1'b0, $unsigned(ox * ox)} + {1'b0, $unsigned(oy * oy)};
        c.hit = 1'b0;
        if (!d2[64])
        begin
            d2c = d2[63:0];
            if (d2c < MIN_DIST_SQ)
            begin
                d2c = MIN_DIST_SQ;
            end
            if (d2c < rs * rs)
            begin
                len = longint'(root64(d2c));
                depth = longint'(rs) - len;
                nx = (ox * 65536) / len;
                ny = (oy * 65536) / len;
                px = fl_shift(nx * depth, 17);
                py = fl_shift(ny * depth, 17);
                c.hit = 1'b1;
                ax = clamp32(ax - px);
                ay = clamp32(ay - py);
                bx = clamp32(bx + px);
                by = clamp32(by + py);
                rel = fl_shift((ax - bx) * nx + (ay - by) * ny, 16);
                ex = fl_shift((65536 + longint'(bnc)) * rel, 16);
                if (ex > 0)
                begin
                    qx = fl_shift(nx * ex, 17);
                    qy = fl_shift(ny * ex, 17);
                    ax = clamp32(ax - qx);
                    ay = clamp32(ay - qy);
                    bx = clamp32(bx + qx);
                    by = clamp32(by + qy);
                end
            end
        end
        c.ndx1 = ax[31:0];
        c.ndy1 = ay[31:0];
        c.ndx2 = bx[31:0];
        c.ndy2 = by[31:0];
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Output side: checker and receiver backpressure
    always @(posedge clk)
    begin
        contact_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (contact_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = contact_q.pop_front();
                if (m_tdata[31:0] !== want.ndx1)
                    report_mismatch("new_first_dx", m_tdata[31:0], want.ndx1);
                if (m_tdata[63:32] !== want.ndy1)
                    report_mismatch("new_first_dy", m_tdata[63:32], want.ndy1);
                if (m_tdata[95:64] !== want.ndx2)
                    report_mismatch("new_second_dx", m_tdata[95:64], want.ndx2);
                if (m_tdata[127:96] !== want.ndy2)
                    report_mismatch("new_second_dy", m_tdata[127:96], want.ndy2);
                if (m_tuser[0] !== want.hit)
                    report_mismatch("overlapped", 32'(m_tuser), 32'(want.hit));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid drops only in idle cycles, so back-to-back sends keep it high
    task automatic send_pair(input logic [319:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        contact_q.push_back(resolve_pair(d, bounce_q));
        @(negedge clk);
    endtask

    function automatic logic [319:0] pack_pair(
        input logic [31:0] p0x, p0y, ax, ay, input logic [30:0] r0,
        input logic [31:0] p1x, p1y, bx, by, input logic [30:0] r1);
        return {2'b00, r1, by, bx, p1y, p1x, r0, ay, ax, p0y, p0x};
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    // Mostly near pairs so the overlap path is taken with random content
    function automatic logic [319:0] rnd_pair();
        logic [31:0] cx, cy;
        logic [30:0] r0, r1;
        if ($urandom_range(9) < 7)
        begin
            cx = $urandom;
            cy = $urandom;
            r0 = 31'($urandom_range(1 << 20));
            r1 = 31'($urandom_range(1 << 20));
            if ($urandom_range(9) == 0)
            begin
                r0 = 31'($urandom);
                r1 = 31'($urandom);
            end
            return pack_pair(cx, cy, rnd_word(), rnd_word(), r0,
                             cx + 32'($signed($urandom_range(1 << 21)) - (1 << 20)),
                             cy + 32'($signed($urandom_range(1 << 21)) - (1 << 20)),
                             rnd_word(), rnd_word(), r1);
        end
        return pack_pair($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                         $urandom, $urandom, $urandom, $urandom, 31'($urandom));
    endfunction

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        while (contact_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (80) @(negedge clk);
    endtask

    task automatic write_bounce(input logic [16:0] v);
        drain_and_wait();
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        bounce_q = v;
    endtask

    task automatic test_directed();
        send_pair(pack_pair(0, 0, 0, 0, 31'd0, 0, 0, 0, 0, 31'd0));
        // coincident centers
        send_pair(pack_pair(32'h10000, 32'h10000, 32'h1234, 32'hfff0_0000, 31'h10000,
                            32'h10000, 32'h10000, 32'h5, 32'h7, 31'h10000));
        // head-on approach
        send_pair(pack_pair(0, 0, 32'h8000, 0, 31'h10000,
                            32'h18000, 0, 32'hffff8000, 0, 31'h10000));
        send_pair(pack_pair(0, 0, 32'h80000000, 32'h7fffffff, 31'h7fffffff,
                            32'h100, 32'h100, 32'h7fffffff, 32'h80000000, 31'h7fffffff));
        // offsets beyond 64 bits of squared distance, then one just within 64 bits
        send_pair(pack_pair(32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 0, 0, 31'h7fffffff));
        send_pair(pack_pair(32'h7fffffff, 0, 32'h100, 32'h200, 31'h7fffffff,
                            32'h80000000, 0, 32'hffffff00, 0, 31'h1));
        // just touching, no overlap; then just overlapping
        send_pair(pack_pair(0, 0, 32'h1000, 0, 31'h10000,
                            32'h20000, 0, 32'hfffff000, 0, 31'h10000));
        send_pair(pack_pair(0, 0, 32'h1000, 0, 31'h10000,
                            32'h1ffff, 0, 32'hfffff000, 0, 31'h10000));
        // separating pair: push only
        send_pair(pack_pair(0, 0, 32'hffff0000, 32'h100, 31'h10000,
                            32'h8000, 32'h4000, 32'h10000, 0, 31'h10000));
        send_pair(pack_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                            31'h7fffffff, 32'hffffffff, 0, 32'h7fffffff, 32'h7fffffff,
                            31'h7fffffff));
    endtask

    task automatic test_random(input int n);
        repeat (n)
        begin
            send_pair(rnd_pair());
        end
    endtask

    // more pairs than the pipeline and queue hold, so s_tready must fall
    task automatic test_backpressure();
        hold_off = 300;
        test_random(100);
    endtask

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        hold_off = 0;
        send_idle_pct = 29;
        recv_idle_pct = 60;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        bounce_q = BOUNCE_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(130);
        test_backpressure();
        write_bounce(17'd0);
        test_directed();
        send_idle_pct = 60;
        recv_idle_pct = 29;
        test_random(130);
        write_bounce(17'd65536);
        test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);
        write_bounce(17'h1ffff);
        test_random(30);
        write_bounce(17'($urandom_range(65536)));
        test_random(30);
        drain_and_wait();
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
